### src/sksub_pkg.sv
// Shared constants, codes and types for the sorted k-subset enumerator.
package sksub_pkg;

  // Store geometry.
  localparam int MAX_ELEMENTS = 16;
  localparam int VALUE_BITS   = 8;
  localparam int MAX_K        = 16;

  // Field and counter widths.
  localparam int OP_W  = 2;
  localparam int K_W   = 5;
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int IDX_W = $clog2(MAX_ELEMENTS);
  localparam int KI_W  = $clog2(MAX_K);

  // Reset value of the subset size register.
  localparam logic [K_W-1:0] K_RESET = K_W'(3);

  // Operation codes carried by an input transaction.
  localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0] OP_ADVANCE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_LD_RD,
    S_LD_CMP,
    S_INIT,
    S_EMIT,
    S_REFILL
  } state_t;

endpackage

### src/sorted_k_subset_enumerator.sv
// Top level of the sorted k-subset enumerator: sequencer around two RAMs.
//
// Channel   Handshake                  Payload
// input     start / busy               op, value
// result    result_valid (strobe)      element, last_in_subset, exhausted
// config    cfg_valid / cfg_ready      cfg_data (subset size K)
//
// One transaction is worked on at a time; busy is high while it runs.
// A load moves each stored value that is larger up one place, a read and then a
// compare and write per value, since the value RAM has a single read port; it ends
// with a compare and write, or a direct write if the value lands at the bottom.
// An advance that starts a new enumeration first sets up the index vector, then
// streams the subset (one element per cycle), then refills the index vector when
// a next subset exists.
// An exhausted result, a clear or a dropped load finish in the accepting cycle.
// Synchronous active-high reset clears control state; the RAMs need no clearing.
// Results are strobed for one cycle and cannot be stalled by the receiver.
module sorted_k_subset_enumerator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [sksub_pkg::OP_W-1:0]        op,
  input  logic [sksub_pkg::VALUE_BITS-1:0]  value,
  output logic                              result_valid,
  output logic [sksub_pkg::VALUE_BITS-1:0]  element,
  output logic                              last_in_subset,
  output logic                              exhausted,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sksub_pkg::K_W-1:0]         cfg_data
);

  import sksub_pkg::*;

  state_t state, state_next;

  logic [K_W-1:0]        k;
  logic [CNT_W-1:0]      count;
  logic                  started;
  logic                  done;
  logic [IDX_W-1:0]      pos;
  logic [VALUE_BITS-1:0] ld_val;
  logic [K_W-1:0]        ic;
  logic                  p1_valid;
  logic [KI_W-1:0]       p1_i;
  logic                  p2_valid;
  logic [KI_W-1:0]       p2_i;
  logic                  l_found;
  logic [KI_W-1:0]       l_pos;
  logic [IDX_W-1:0]      l_val;
  logic [KI_W-1:0]       ji;
  logic [IDX_W-1:0]      rv;

  // RAM ports.
  logic                  vals_we;
  logic [IDX_W-1:0]      vals_waddr;
  logic [VALUE_BITS-1:0] vals_wdata;
  logic [IDX_W-1:0]      vals_raddr;
  logic [VALUE_BITS-1:0] vals_rdata;
  logic                  idx_we;
  logic [KI_W-1:0]       idx_waddr;
  logic [IDX_W-1:0]      idx_wdata;
  logic [KI_W-1:0]       idx_raddr;
  logic [IDX_W-1:0]      idx_rdata;

  logic                  accept;
  logic                  cfg_write;
  logic                  no_subset;
  logic                  issue;
  logic [K_W:0]          target;
  logic                  emit_last;

  assign accept    = start && !busy;
  assign cfg_write = cfg_valid && cfg_ready;
  assign busy      = (state != S_IDLE);
  assign cfg_ready = !busy;

  // An advance gives an exhausted result when no subset can be formed.
  assign no_subset = done || (k == '0) || ({1'b0, k} > (K_W+1)'(MAX_K)) ||
                     ((K_W+1)'(k) > (K_W+1)'(count));

  assign issue     = (state == S_EMIT) && (ic < k);
  assign target    = (K_W+1)'(count) - (K_W+1)'(k) + (K_W+1)'(p1_i);
  assign emit_last = p2_valid && (K_W'(p2_i) == k - K_W'(1));

  // Sorted values, kept in ascending order.
  sksub_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ELEMENTS)) u_vals (
    .clk   (clk),
    .we    (vals_we),
    .waddr (vals_waddr),
    .wdata (vals_wdata),
    .raddr (vals_raddr),
    .rdata (vals_rdata)
  );

  // Current index vector of the subset.
  sksub_ram #(.WIDTH(IDX_W), .DEPTH(MAX_K)) u_idx (
    .clk   (clk),
    .we    (idx_we),
    .waddr (idx_waddr),
    .wdata (idx_wdata),
    .raddr (idx_raddr),
    .rdata (idx_rdata)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and RAM port control.
  always_comb begin
    state_next = state;
    vals_we    = 1'b0;
    vals_waddr = pos;
    vals_wdata = ld_val;
    vals_raddr = idx_rdata;
    idx_we     = 1'b0;
    idx_waddr  = ic[KI_W-1:0];
    idx_wdata  = IDX_W'(ic);
    idx_raddr  = ic[KI_W-1:0];
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (op == OP_LOAD && count < CNT_W'(MAX_ELEMENTS)) begin
            state_next = S_LD_RD;
          end else if (op == OP_ADVANCE && !no_subset) begin
            state_next = started ? S_EMIT : S_INIT;
          end
        end
      end
      S_LD_RD: begin
        if (pos == '0) begin
          vals_we    = 1'b1;
          state_next = S_IDLE;
        end else begin
          vals_raddr = pos - IDX_W'(1);
          state_next = S_LD_CMP;
        end
      end
      S_LD_CMP: begin
        vals_we = 1'b1;
        if (vals_rdata > ld_val) begin
          vals_wdata = vals_rdata;
          state_next = S_LD_RD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_INIT: begin
        idx_we = 1'b1;
        if (ic == k - K_W'(1)) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_last) begin
          state_next = l_found ? S_REFILL : S_IDLE;
        end
      end
      S_REFILL: begin
        idx_we    = 1'b1;
        idx_waddr = ji;
        idx_wdata = rv;
        if (K_W'(ji) == k - K_W'(1)) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state: store fill, enumeration flags and the subset size.
  always_ff @(posedge clk) begin
    if (rst) begin
      k            <= K_RESET;
      count        <= '0;
      started      <= 1'b0;
      done         <= 1'b0;
      result_valid <= 1'b0;
      p1_valid     <= 1'b0;
      p2_valid     <= 1'b0;
      l_found      <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_write) begin
        k       <= cfg_data;
        started <= 1'b0;
        done    <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (op == OP_LOAD && count < CNT_W'(MAX_ELEMENTS)) begin
              started <= 1'b0;
              done    <= 1'b0;
            end else if (op == OP_ADVANCE) begin
              if (no_subset) begin
                result_valid <= 1'b1;
              end
            end else if (op == OP_CLEAR) begin
              count   <= '0;
              started <= 1'b0;
              done    <= 1'b0;
            end
          end
          p1_valid <= 1'b0;
          p2_valid <= 1'b0;
          l_found  <= 1'b0;
        end
        S_LD_RD: begin
          if (pos == '0) begin
            count <= count + CNT_W'(1);
          end
        end
        S_LD_CMP: begin
          if (!(vals_rdata > ld_val)) begin
            count <= count + CNT_W'(1);
          end
        end
        S_INIT: begin
          started <= 1'b1;
        end
        S_EMIT: begin
          p1_valid     <= issue;
          p2_valid     <= p1_valid;
          result_valid <= p2_valid;
          if (p1_valid && (K_W+1)'(idx_rdata) != target) begin
            l_found <= 1'b1;
          end
          if (emit_last && !l_found) begin
            done <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers: load position, counters and result payload.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        pos            <= count[IDX_W-1:0];
        ld_val         <= value;
        ic             <= '0;
        element        <= '0;
        last_in_subset <= 1'b1;
        exhausted      <= 1'b1;
      end
      S_LD_CMP: begin
        if (vals_rdata > ld_val) begin
          pos <= pos - IDX_W'(1);
        end
      end
      S_INIT: begin
        ic <= (ic == k - K_W'(1)) ? '0 : ic + K_W'(1);
      end
      S_EMIT: begin
        if (issue) begin
          ic <= ic + K_W'(1);
        end
        p1_i <= ic[KI_W-1:0];
        p2_i <= p1_i;
        if (p1_valid && (K_W+1)'(idx_rdata) != target) begin
          l_pos <= p1_i;
          l_val <= idx_rdata;
        end
        element        <= vals_rdata;
        last_in_subset <= emit_last;
        exhausted      <= 1'b0;
        ji             <= l_pos;
        rv             <= l_val + IDX_W'(1);
      end
      S_REFILL: begin
        ji <= ji + KI_W'(1);
        rv <= rv + IDX_W'(1);
      end
      default: begin
      end
    endcase
  end

  // An exhausted result always carries a zero element and the last mark.
  a_exhausted_form: assert property (@(posedge clk) disable iff (rst)
    result_valid && exhausted |-> element == '0 && last_in_subset)
    else $error("exhausted result with nonzero element or no last mark");

  // Subset elements come out of the streaming pass only.
  a_elem_from_emit: assert property (@(posedge clk) disable iff (rst)
    result_valid && !exhausted |-> $past(state) == S_EMIT)
    else $error("subset element outside the streaming pass");

  // The store never holds more than its depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ELEMENTS))
    else $error("store fill count beyond depth");

  // The issue counter never runs past K while streaming.
  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT |-> ic <= k)
    else $error("index read issued beyond subset size");

endmodule

### src/sksub_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module sksub_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sim/testbench.sv
// Self-checking testbench for the sorted k-subset enumerator.
`timescale 1ns / 100ps

module testbench;
  import sksub_pkg::*;

  // Code for an item that the block ignores.
  localparam logic [OP_W-1:0] OP_NOP = 2'd3;

  localparam int ITEM_TARGET   = 300;
  localparam int SETTLE_CYCLES = 2 * MAX_ELEMENTS + 4;
  localparam int END_CYCLES    = 60;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int REPORT_LIMIT  = 10;

  // One subset element as it leaves the block.
  typedef struct packed {
    logic [VALUE_BITS-1:0] element;
    logic                  last;
    logic                  exh;
  } subset_elem_t;

  typedef enum logic [1:0] {STEP_ITEM, STEP_CONFIG, STEP_SETTLE} step_kind_t;

  // One entry of the stimulus plan.
  typedef struct {
    step_kind_t            kind;
    logic [OP_W-1:0]       code;
    logic [VALUE_BITS-1:0] data;
    int                    gap;
  } step_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [OP_W-1:0]       op = OP_LOAD;
  logic [VALUE_BITS-1:0] value = '0;
  logic                  result_valid;
  logic [VALUE_BITS-1:0] element;
  logic                  last_in_subset;
  logic                  exhausted;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [K_W-1:0]        cfg_data = '0;

  step_t        plan_q[$];
  subset_elem_t subset_expect_q[$];
  subset_elem_t subset_seen_q[$];

  // Shadow copy of the enumerator state.
  logic [VALUE_BITS-1:0] m_vals [MAX_ELEMENTS];
  logic [IDX_W-1:0]      m_idx  [MAX_K];
  int                    m_count   = 0;
  logic                  m_started = 1'b0;
  logic                  m_done    = 1'b0;
  logic [K_W-1:0]        m_k       = K_RESET;

  int  mismatches   = 0;
  int  items_queued = 0;
  int  gap_left     = -1;
  int  settle       = 0;
  int  cycles       = 0;
  bit  burst_phase  = 1'b0;

  sorted_k_subset_enumerator dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .op             (op),
    .value          (value),
    .result_valid   (result_valid),
    .element        (element),
    .last_in_subset (last_in_subset),
    .exhausted      (exhausted),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // A register write restarts the enumeration.
  task automatic apply_subset_size(input logic [K_W-1:0] k_new);
    m_k       = k_new;
    m_started = 1'b0;
    m_done    = 1'b0;
  endtask

  // Update the shadow state for one accepted transaction and queue its subset elements.
  task automatic step_enumerator(input logic [OP_W-1:0] code,
                                 input logic [VALUE_BITS-1:0] v);
    int pos;
    int k;
    int l;
    subset_elem_t r;
    k = int'(m_k);
    case (code)
      OP_LOAD: begin
        if (m_count < MAX_ELEMENTS) begin
          // Insertion sort: equal values go after the stored ones.
          pos = m_count;
          while (pos > 0 && m_vals[pos-1] > v) begin
            m_vals[pos] = m_vals[pos-1];
            pos--;
          end
          m_vals[pos] = v;
          m_count++;
          m_started = 1'b0;
          m_done    = 1'b0;
        end
      end
      OP_ADVANCE: begin
        if (m_done || k == 0 || k > MAX_K || k > m_count) begin
          r = '{element: '0, last: 1'b1, exh: 1'b1};
          subset_expect_q.push_back(r);
        end else begin
          if (!m_started) begin
            for (int i = 0; i < k; i++) m_idx[i] = IDX_W'(i);
            m_started = 1'b1;
          end
          for (int i = 0; i < k; i++) begin
            r = '{element: m_vals[m_idx[i]], last: (i == k - 1), exh: 1'b0};
            subset_expect_q.push_back(r);
          end
          // Step to the next index vector in lexicographic order.
          l = k - 1;
          while (l >= 0 && int'(m_idx[l]) == m_count - k + l) l--;
          if (l >= 0) begin
            m_idx[l] = m_idx[l] + 1'b1;
            for (int j = l + 1; j < k; j++) m_idx[j] = m_idx[l] + IDX_W'(j - l);
          end else begin
            m_done = 1'b1;
          end
        end
      end
      OP_CLEAR: begin
        m_count   = 0;
        m_started = 1'b0;
        m_done    = 1'b0;
      end
      default: begin
      end
    endcase
  endtask

  task automatic queue_item(input logic [OP_W-1:0] code, input logic [VALUE_BITS-1:0] v);
    step_t s;
    s = '{kind: STEP_ITEM, code: code, data: v,
          gap: burst_phase ? 0 : $urandom_range(0, 8)};
    plan_q.push_back(s);
    if (code != OP_NOP) items_queued++;
  endtask

  task automatic queue_config(input int k_new);
    step_t s;
    s = '{kind: STEP_CONFIG, code: OP_LOAD, data: VALUE_BITS'(k_new), gap: 0};
    plan_q.push_back(s);
  endtask

  task automatic queue_settle();
    step_t s;
    s = '{kind: STEP_SETTLE, code: OP_LOAD, data: '0, gap: 0};
    plan_q.push_back(s);
  endtask

  // Driver: presents planned transactions and register writes, one at a time.
  always @(posedge clk) begin : driver
    step_t nxt;
    logic  go;
    logic  wr;
    if (rst) begin
      start     <= 1'b0;
      cfg_valid <= 1'b0;
      gap_left  = -1;
      settle    = 0;
    end else begin
      go = start;
      wr = cfg_valid;
      if (start && !busy) begin
        step_enumerator(op, value);
        go = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        apply_subset_size(cfg_data);
        wr = 1'b0;
      end
      if (!go && !wr && plan_q.size() > 0) begin
        nxt = plan_q[0];
        case (nxt.kind)
          STEP_ITEM: begin
            if (gap_left < 0) gap_left = nxt.gap;
            if (gap_left > 0) begin
              gap_left--;
            end else begin
              op    <= nxt.code;
              value <= nxt.data;
              go       = 1'b1;
              gap_left = -1;
              void'(plan_q.pop_front());
            end
          end
          STEP_CONFIG: begin
            cfg_data <= nxt.data[K_W-1:0];
            wr = 1'b1;
            void'(plan_q.pop_front());
          end
          default: begin
            // Hold off until all results are in and the block has gone quiet.
            if (subset_expect_q.size() == 0 && !busy) settle++;
            else settle = 0;
            if (settle >= SETTLE_CYCLES) begin
              settle = 0;
              void'(plan_q.pop_front());
            end
          end
        endcase
      end
      start     <= go;
      cfg_valid <= wr;
    end
  end

  // Monitor: collects strobed results and checks them against the oldest expectation.
  always @(posedge clk) begin : monitor
    subset_elem_t got;
    subset_elem_t want;
    if (!rst && result_valid) begin
      got = '{element: element, last: last_in_subset, exh: exhausted};
      subset_seen_q.push_back(got);
    end
    while (subset_seen_q.size() > 0 && subset_expect_q.size() > 0) begin
      got  = subset_seen_q.pop_front();
      want = subset_expect_q.pop_front();
      if (got.element !== want.element || got.last !== want.last || got.exh !== want.exh) begin
        if (mismatches < REPORT_LIMIT)
          $display("mismatch: expected element=%0d last=%0b exhausted=%0b",
                   want.element, want.last, want.exh,
                   " got element=%0d last=%0b exhausted=%0b",
                   got.element, got.last, got.exh);
        mismatches++;
      end
    end
  end

  // Watchdog on the total run length.
  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Stimulus plan, reset and end of run.
  initial begin : sequencer
    int k_sched [7] = '{1, 16, 0, 31, 17, 2, 15};
    int phase;
    int k;
    int kk;
    int n;
    int stored;
    int loads;
    int combos;
    int adv;
    int stray;

    // Directed part: empty store, extreme values, duplicates, full enumeration.
    queue_item(OP_ADVANCE, 8'hA5);
    queue_item(OP_LOAD, 8'hFF);
    queue_item(OP_LOAD, 8'h00);
    queue_item(OP_LOAD, 8'h80);
    queue_item(OP_LOAD, 8'h00);
    queue_item(OP_LOAD, 8'hFF);
    repeat (11) queue_item(OP_ADVANCE, 8'h00);
    queue_item(OP_ADVANCE, 8'hFF);
    // A load after exhaustion restarts from the first subset.
    queue_item(OP_LOAD, 8'h07);
    queue_item(OP_ADVANCE, 8'h00);
    queue_item(OP_CLEAR, 8'h5A);
    queue_item(OP_ADVANCE, 8'h00);
    queue_item(OP_NOP, 8'h3C);
    stored = 0;

    // Random phases, each under its own subset size.
    phase = 0;
    while (items_queued < ITEM_TARGET) begin
      queue_settle();
      if (phase < $size(k_sched)) k = k_sched[phase];
      else if ($urandom_range(0, 7) == 0) k = $urandom_range(0, 31);
      else k = $urandom_range(1, 6);
      queue_config(k);
      phase++;
      burst_phase = ($urandom_range(0, 3) == 0);

      if ($urandom_range(0, 3) != 0) begin
        queue_item(OP_CLEAR, VALUE_BITS'($urandom_range(0, 255)));
        stored = 0;
      end

      // Pick a store size that keeps the subset count modest.
      kk = (k >= 1 && k <= MAX_K) ? k : $urandom_range(1, 6);
      if (kk == 1) n = $urandom_range(1, MAX_ELEMENTS);
      else if (kk >= 6) n = kk + $urandom_range(0, 1);
      else n = kk + $urandom_range(0, 3);
      if ($urandom_range(0, 9) == 0) n = kk - 1;
      if (n > MAX_ELEMENTS) n = MAX_ELEMENTS;

      loads = (n > stored) ? n - stored : 0;
      if (n == MAX_ELEMENTS) loads += $urandom_range(0, 2);
      repeat (loads) begin
        if ($urandom_range(0, 3) == 0) queue_item(OP_LOAD, VALUE_BITS'($urandom_range(0, 3)));
        else queue_item(OP_LOAD, VALUE_BITS'($urandom_range(0, 255)));
      end
      stored = (stored + loads > MAX_ELEMENTS) ? MAX_ELEMENTS : stored + loads;

      combos = 0;
      if (k >= 1 && k <= stored) begin
        combos = 1;
        for (int i = 0; i < k; i++) combos = combos * (stored - i) / (i + 1);
      end

      // Walk to exhaustion and past it, with occasional disturbances.
      adv = combos + $urandom_range(1, 2);
      repeat (adv) begin
        case ($urandom_range(0, 39))
          0, 1: begin
            queue_item(OP_LOAD, VALUE_BITS'($urandom_range(0, 255)));
            if (stored < MAX_ELEMENTS) stored++;
          end
          2: queue_item(OP_NOP, VALUE_BITS'($urandom_range(0, 255)));
          3: begin
            queue_item(OP_CLEAR, VALUE_BITS'($urandom_range(0, 255)));
            stored = 0;
          end
          4: begin
            queue_settle();
            queue_config(k);
          end
          default: queue_item(OP_ADVANCE, VALUE_BITS'($urandom_range(0, 255)));
        endcase
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (plan_q.size() != 0 || start || cfg_valid || subset_expect_q.size() != 0);
    repeat (END_CYCLES) @(posedge clk);

    stray = subset_seen_q.size();
    if (stray != 0) $display("%0d results arrived with no expectation waiting", stray);
    if (mismatches == 0 && stray == 0 && subset_expect_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### sorted_k_subset_enumerator.f
src/sksub_pkg.sv
src/sksub_ram.sv
src/sorted_k_subset_enumerator.sv
sim/testbench.sv
